// File: rtl/dfrp_pkg.sv
// Shared types and character constants for the decimal field row parser.
`default_nettype none

package dfrp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int VALUE_W  = 32;
   localparam int COLUMN_W = 10;

   // Index of the only configuration register.
   localparam logic REG_ALTITUDE_OFFSET = 1'b0;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] height_value;
      logic                      value_valid;
      logic [COLUMN_W-1:0]       column_index;
      logic                      row_end;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/dfrp_csr.sv
// Configuration register block holding the altitude offset.
`default_nettype none

module dfrp_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [2:0]                         csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready,
   output logic signed [dfrp_pkg::VALUE_W-1:0]     altitude_offset
);
   import dfrp_pkg::*;

   logic signed [VALUE_W-1:0] offset_ff;
   logic signed [VALUE_W-1:0] offset_in;
   logic                      reg_index;

   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;

   always_comb begin
      offset_in = offset_ff;
      if (csr_psel && csr_penable && csr_pwrite && (reg_index == REG_ALTITUDE_OFFSET)) begin
         offset_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ALTITUDE_OFFSET: csr_prdata = offset_ff;
         default:             csr_prdata = '0;
      endcase
   end

   assign altitude_offset = offset_ff;

endmodule

`default_nettype wire

// File: rtl/dfrp_step.sv
// Input register, tokenizer state, per-byte step logic and result register.
`default_nettype none

module dfrp_step #(
   parameter int MAX_COLUMNS = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_text_byte,
   input  wire logic signed [dfrp_pkg::VALUE_W-1:0] altitude_offset,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output dfrp_pkg::result_type                    rsp_result
);
   import dfrp_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff, in_byte_in;
   phase_type                 phase_ff, phase_in;
   logic                      neg_ff, neg_in;
   logic [VALUE_W-1:0]        mag_ff, mag_in;
   logic [CW-1:0]             col_ff, col_in;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_ff, out_in;

   logic                      req_accept;
   logic                      step_fire;
   logic                      res_gen;
   result_type                res_d;
   logic                      is_digit;
   logic [VALUE_W-1:0]        digit_val;
   logic [VALUE_W-1:0]        signed_mag;
   logic [CW:0]               col_next;
   logic [CW-1:0]             col_wrap;

   assign is_digit   = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign digit_val  = VALUE_W'(in_byte_ff - CHAR_ZERO);
   assign signed_mag = neg_ff ? (VALUE_W'(0) - mag_ff) : mag_ff;
   assign col_next   = {1'b0, col_ff} + (CW+1)'(1);
   assign col_wrap   = (col_next >= (CW+1)'(MAX_COLUMNS)) ? '0 : col_next[CW-1:0];

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      col_in   = col_ff;
      res_gen  = 1'b0;
      res_d    = '0;
      unique case (phase_ff) inside
         PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
               mag_in   = (mag_ff << 3) + (mag_ff << 1) + digit_val;
               phase_in = PH_DIGITS;
            end else begin
               // The token ends here; the offset applies only to a nonzero value.
               res_gen            = 1'b1;
               res_d.value_valid  = 1'b1;
               res_d.height_value = (signed_mag != '0) ? (signed_mag + altitude_offset)
                                                       : signed_mag;
               res_d.column_index = COLUMN_W'(col_ff);
               neg_in             = 1'b0;
               mag_in             = '0;
               col_in             = col_wrap;
               if (in_byte_ff == CHAR_NUL) begin
                  res_d.row_end = 1'b1;
                  phase_in      = PH_IDLE;
                  col_in        = '0;
               end else if (in_byte_ff == CHAR_SPACE) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_IDLE, PH_SKIP: begin
            if (in_byte_ff == CHAR_NUL) begin
               res_gen            = 1'b1;
               res_d.row_end      = 1'b1;
               res_d.column_index = COLUMN_W'(col_ff);
               phase_in           = PH_IDLE;
               col_in             = '0;
            end else if (phase_ff == PH_SKIP) begin
               if (in_byte_ff == CHAR_SPACE) begin
                  phase_in = PH_IDLE;
               end
            end else if (is_digit) begin
               neg_in   = 1'b0;
               mag_in   = digit_val;
               phase_in = PH_DIGITS;
            end else if (in_byte_ff == CHAR_MINUS) begin
               neg_in   = 1'b1;
               mag_in   = '0;
               phase_in = PH_SIGN;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // A byte that yields nothing may step even while a result waits.
   assign step_fire  = in_valid_ff && (!res_gen || !out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !step_fire;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step_fire && res_gen) begin
         out_valid_in = 1'b1;
         out_in       = res_d;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         col_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            mag_ff   <= mag_in;
            col_ff   <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   // A result without a value only ever closes a row and carries zero.
   a_empty_result_is_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result.value_valid) |->
         (rsp_result.row_end && (rsp_result.height_value == '0)))
      else $error("result without value is not a plain row end");

   // Closing a row restarts the column count.
   a_row_end_clears_column: assert property (@(posedge clock) disable iff (reset)
      (step_fire && res_gen && res_d.row_end) |=> (col_ff == '0))
      else $error("column counter not cleared after row end");

   // Outside a number the accumulator is empty, and the sign is set only in a token.
   a_idle_state_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DIGITS) |->
         ((mag_ff == '0) && (neg_ff == 1'b0 || phase_ff == PH_SIGN)))
      else $error("stale token state outside a number");

endmodule

`default_nettype wire

// File: rtl/decimal_field_row_parser.sv
// Top level of the decimal field row parser: configuration port and tokenizer.
`default_nettype none

// Takes height-map text one byte per cycle and emits one item for each signed
// decimal token (value plus altitude offset when nonzero, with its column) and
// one item for each row end (byte 0) that closes no token. A new byte is taken
// in every cycle while results are being taken; a byte passes an input register
// and the combinational tokenizer step into the result register. Only a byte that
// produces a result waits for a full result register to drain. The altitude
// offset sits at byte address 0 of the configuration port.
module decimal_field_row_parser #(
   parameter int MAX_COLUMNS = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_text_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [dfrp_pkg::VALUE_W-1:0]     rsp_height_value,
   output logic                                    rsp_value_valid,
   output logic [dfrp_pkg::COLUMN_W-1:0]           rsp_column_index,
   output logic                                    rsp_row_end,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [2:0]                         csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);
   import dfrp_pkg::*;

   logic signed [VALUE_W-1:0] altitude_offset;
   result_type                result;

   dfrp_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .altitude_offset (altitude_offset)
   );

   dfrp_step #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_step (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .altitude_offset (altitude_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (result)
   );

   assign rsp_height_value = result.height_value;
   assign rsp_value_valid  = result.value_valid;
   assign rsp_column_index = result.column_index;
   assign rsp_row_end      = result.row_end;

endmodule

`default_nettype wire

// File: tb/tb_decimal_field_row_parser.sv
// Self-checking testbench for the decimal field row parser: text stream in, parsed heights out.
module tb_decimal_field_row_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import dfrp_pkg::*;

   localparam int          MAX_COLUMNS  = 1024;
   localparam int          IDLE_PCT     = 31;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          SETTLE       = 8;
   localparam int          QUIET_LIMIT  = 3000;
   localparam logic [2:0]  ALT_ADDR     = {REG_ALTITUDE_OFFSET, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_height_value;
   logic        rsp_value_valid;
   logic [COLUMN_W-1:0]       rsp_column_index;
   logic        rsp_row_end;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   decimal_field_row_parser #(.MAX_COLUMNS(MAX_COLUMNS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_height_value(rsp_height_value), .rsp_value_valid(rsp_value_valid),
      .rsp_column_index(rsp_column_index), .rsp_row_end(rsp_row_end),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state, mirroring the tokenizer.
   phase_type   scan_state = PH_IDLE;
   bit          minus_seen = 1'b0;
   logic [31:0] magnitude = 32'd0;
   int          column = 0;
   logic [31:0] altitude = 32'd0;

   logic [7:0]  text_backlog[$];
   result_type  heights_due[$];
   int          bytes_queued = 0;
   int          mismatches = 0;
   int          req_idle_pct = IDLE_PCT;
   int          rsp_idle_pct = IDLE_PCT;
   int          holds_asked = 0;

   function automatic bit tokenize_byte(input logic [7:0] c, output result_type r);
      logic [31:0] v;
      bit          is_num;
      is_num = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      r = '0;
      if (scan_state == PH_SIGN || scan_state == PH_DIGITS) begin
         if (is_num) begin
            magnitude = magnitude * 32'd10 + 32'(c - CHAR_ZERO);
            scan_state = PH_DIGITS;
            return 1'b0;
         end
         v = minus_seen ? -magnitude : magnitude;
         if (v != 32'd0) v = v + altitude;
         r.height_value = v;
         r.value_valid = 1'b1;
         r.column_index = column[COLUMN_W-1:0];
         r.row_end = (c == CHAR_NUL);
         column = (column + 1 >= MAX_COLUMNS) ? 0 : column + 1;
         minus_seen = 1'b0;
         magnitude = 32'd0;
         if (c == CHAR_NUL) begin
            scan_state = PH_IDLE;
            column = 0;
         end else begin
            scan_state = (c == CHAR_SPACE) ? PH_IDLE : PH_SKIP;
         end
         return 1'b1;
      end
      // A row end with no token pending reports how many values the row held.
      if (c == CHAR_NUL) begin
         r.column_index = column[COLUMN_W-1:0];
         r.row_end = 1'b1;
         scan_state = PH_IDLE;
         column = 0;
         return 1'b1;
      end
      if (scan_state == PH_SKIP) begin
         if (c == CHAR_SPACE) scan_state = PH_IDLE;
         return 1'b0;
      end
      if (is_num) begin
         minus_seen = 1'b0;
         magnitude = 32'(c - CHAR_ZERO);
         scan_state = PH_DIGITS;
      end else if (c == CHAR_MINUS) begin
         minus_seen = 1'b1;
         magnitude = 32'd0;
         scan_state = PH_SIGN;
      end
      return 1'b0;
   endfunction

   function automatic void report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
   endfunction

   // Sender: one byte per accepted item, with random gaps.
   always @(posedge clock) begin
      logic       valid_next;
      logic [7:0] byte_next;
      result_type r;
      valid_next = req_valid;
      byte_next = req_text_byte;
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (tokenize_byte(req_text_byte, r)) heights_due.push_back(r);
            valid_next = 1'b0;
         end
         if (!valid_next && text_backlog.size() > 0 &&
             $urandom_range(99) >= req_idle_pct) begin
            valid_next = 1'b1;
            byte_next = text_backlog.pop_front();
         end
      end
      req_valid <= valid_next;
      req_text_byte <= byte_next;
   end

   // Receiver: checks each result and drives its own stall, including long holds.
   int holds_done = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      result_type want;
      bit         stall_next;
      if (reset) begin
         stall_next = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (heights_due.size() == 0) begin
               report_mismatch($sformatf(
                  "unexpected item: value %0d valid %0b column %0d row_end %0b",
                  rsp_height_value, rsp_value_valid, rsp_column_index, rsp_row_end));
            end else begin
               want = heights_due.pop_front();
               if (rsp_height_value !== want.height_value ||
                   rsp_value_valid !== want.value_valid ||
                   rsp_column_index !== want.column_index ||
                   rsp_row_end !== want.row_end) begin
                  report_mismatch($sformatf(
                     {"expected value %0d valid %0b column %0d row_end %0b, ",
                      "got value %0d valid %0b column %0d row_end %0b"},
                     want.height_value, want.value_valid, want.column_index, want.row_end,
                     rsp_height_value, rsp_value_valid, rsp_column_index, rsp_row_end));
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (holds_done < holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            stall_next = 1'b1;
         end else begin
            stall_next = ($urandom_range(99) < rsp_idle_pct);
         end
      end
      rsp_stall <= stall_next;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || csr_psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_decimal_field_row_parser NOT OK");
      $finish;
   end

   task automatic push_byte(input logic [7:0] b);
      text_backlog.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic queue_number(input int max_digits);
      int len;
      if ($urandom_range(99) < 40) push_byte(CHAR_MINUS);
      len = $urandom_range(max_digits, 1);
      repeat (len) push_byte(CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   // A row of mostly well-formed words with random content, plus broken words and noise.
   task automatic queue_random_row();
      string hex_digits;
      int    words;
      int    kind;
      hex_digits = "0123456789ABCDEF";
      words = $urandom_range(8, 0);
      for (int w = 0; w < words; w++) begin
         kind = $urandom_range(19, 0);
         if (kind < 14) begin
            queue_number(kind < 2 ? 12 : 4);
         end else if (kind == 14) begin
            queue_number(6);
            push_text(",0x");
            repeat ($urandom_range(6, 2)) push_byte(hex_digits[$urandom_range(15)]);
         end else if (kind == 15) begin
            push_byte(CHAR_MINUS);
         end else if (kind == 16) begin
            push_byte(CHAR_MINUS);
            push_byte(CHAR_MINUS);
            repeat ($urandom_range(3, 0)) push_byte(CHAR_ZERO + 8'($urandom_range(9)));
         end else if (kind == 17) begin
            queue_number(3);
            push_byte(8'($urandom_range(255, 33)));
            queue_number(3);
         end else begin
            repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255, 1)));
         end
         if (w != words - 1 || $urandom_range(1))
            repeat ($urandom_range(2, 1)) push_byte(CHAR_SPACE);
      end
      push_byte(CHAR_NUL);
   endtask

   task automatic queue_random_bytes(input int count);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < count) queue_random_row();
   endtask

   task automatic drain_results();
      do @(posedge clock);
      while (text_backlog.size() != 0 || req_valid || heights_due.size() != 0);
      // Bytes that cause no result may still be inside the block.
      repeat (SETTLE) @(posedge clock);
   endtask

   // One configuration access: setup cycle, then access cycle until pready.
   task automatic access_altitude(input bit is_write, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= ALT_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (is_write) begin
         altitude = value;
      end else if (csr_prdata !== altitude) begin
         report_mismatch($sformatf("altitude offset read %h, expected %h",
                                   csr_prdata, altitude));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_altitude(input logic [31:0] value);
      access_altitude(1'b1, value);
      access_altitude(1'b0, 32'd0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      access_altitude(1'b0, 32'd0);

      // Directed: zero, most negative value, repeated sign, terminator inside a
      // word, lone minus at row end, empty row, ignored high bytes, token ended by row end.
      push_text("0 -2147483648 -- 7x5 -");
      push_byte(CHAR_NUL);
      push_byte(CHAR_NUL);
      push_byte(8'hFF);
      push_byte(8'h80);
      push_text(" 3");
      push_byte(CHAR_NUL);
      drain_results();

      set_altitude(32'h7FFF_FFFF);
      queue_random_bytes(120);
      drain_results();

      // Receiver holds off while the sender keeps offering tokens.
      set_altitude(32'h8000_0000);
      req_idle_pct = 0;
      holds_asked++;
      repeat (100) begin
         push_byte(CHAR_ZERO + 8'($urandom_range(9)));
         push_byte(CHAR_SPACE);
      end
      push_byte(CHAR_NUL);
      drain_results();
      req_idle_pct = IDLE_PCT;

      set_altitude(32'hFFFF_FFFF);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      queue_random_bytes(120);
      drain_results();
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;

      set_altitude($urandom);
      queue_random_bytes(120);
      drain_results();

      set_altitude(32'd0);
      queue_random_bytes(120);
      drain_results();

      if (mismatches == 0 && heights_due.size() == 0)
         $display("tb_decimal_field_row_parser OK");
      else
         $display("tb_decimal_field_row_parser NOT OK");
      $finish;
   end

endmodule

// File: decimal_field_row_parser.f
rtl/dfrp_pkg.sv
rtl/dfrp_csr.sv
rtl/dfrp_step.sv
rtl/decimal_field_row_parser.sv
tb/tb_decimal_field_row_parser.sv
